// ===== rtl/core/pmrp_pkg.sv =====
// ----------------------------------------------------------------------------
// pmrp_pkg
// Shared types and constants of the passive-mode reply parser.
// ----------------------------------------------------------------------------
package pmrp_pkg;

   localparam int BYTE_W      = 8;
   localparam int HOST_W      = 10;
   localparam int PORT_W      = 16;
   localparam int PORT_PART_W = 8;
   localparam int COUNT_W     = 3;
   localparam int HOST_COUNT  = 4;
   localparam int HOST_IDX_W  = 2;
   localparam int PORT_ACC_W  = 12;

   localparam logic [COUNT_W-1:0]    PREFIX_LEN  = 3'd4;
   localparam logic [COUNT_W-1:0]    HOST_DIGITS = 3'd3;
   localparam logic [COUNT_W-1:0]    DIGIT_SAT   = 3'd7;
   localparam logic [PORT_ACC_W-1:0] PORT_MAX    = 12'd255;

   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [3:0] {
      PH_PREFIX  = 4'd0,
      PH_SEEK    = 4'd1,
      PH_HOST0   = 4'd2,
      PH_HOST1   = 4'd3,
      PH_HOST2   = 4'd4,
      PH_HOST3   = 4'd5,
      PH_PORT_HI = 4'd6,
      PH_PORT_LO = 4'd7,
      PH_DONE    = 4'd8,
      PH_ERROR   = 4'd9
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] reply_byte;
      logic              last_byte;
   } item_type;

   typedef struct packed {
      logic              valid_res;
      logic [HOST_W-1:0] host_first;
      logic [HOST_W-1:0] host_second;
      logic [HOST_W-1:0] host_third;
      logic [HOST_W-1:0] host_fourth;
      logic [PORT_W-1:0] port_number;
   } result_type;

endpackage

// ===== rtl/core/passive_mode_reply_parser.sv =====
// ----------------------------------------------------------------------------
// passive_mode_reply_parser
// Parses a passive-mode reply, one byte per word, into host numbers and port.
//
// req channel: one reply byte per word, req_last_byte marks the final byte.
// rsp channel: one result word per reply, sent after its final byte.
// Path: input register, then parse logic into the result register.
// Throughput: one byte per cycle while no final byte waits on rsp_stall;
// the parse state updates once per byte in a single pass of compare and
// multiply-by-ten add logic.
// rsp_valid_res low means the reply was malformed; all fields are then zero.
// Reset empties both registers and clears the parse state; the state also
// restarts after every final byte. While rsp_stall holds a pending result,
// ordinary bytes keep flowing; only a further final byte waits, and
// req_stall rises while it sits in the input register.
// ----------------------------------------------------------------------------
module passive_mode_reply_parser
   import pmrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_reply_byte,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_valid_res,
   output logic [HOST_W-1:0] rsp_host_first,
   output logic [HOST_W-1:0] rsp_host_second,
   output logic [HOST_W-1:0] rsp_host_third,
   output logic [HOST_W-1:0] rsp_host_fourth,
   output logic [PORT_W-1:0] rsp_port_number
);

   logic       item_valid;
   item_type   item;
   logic       item_take;
   logic       out_ready;
   result_type res;

   assign item_take = item_valid && (!item.last_byte || out_ready);

   pmrp_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_reply_byte (req_reply_byte),
      .req_last_byte  (req_last_byte),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take)
   );

   pmrp_parse u_parse (
      .clock (clock),
      .reset (reset),
      .step  (item_take),
      .item  (item),
      .res   (res)
   );

   pmrp_out_reg u_out_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (item_take && item.last_byte),
      .res             (res),
      .ready           (out_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_host_first  (rsp_host_first),
      .rsp_host_second (rsp_host_second),
      .rsp_host_third  (rsp_host_third),
      .rsp_host_fourth (rsp_host_fourth),
      .rsp_port_number (rsp_port_number)
   );

endmodule

// ===== rtl/core/pmrp_in_reg.sv =====
// ----------------------------------------------------------------------------
// pmrp_in_reg
// Input register: holds one reply word until the parser takes it.
// ----------------------------------------------------------------------------
module pmrp_in_reg
   import pmrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_reply_byte,
   input  logic              req_last_byte,
   output logic              item_valid,
   output item_type          item,
   input  logic              item_take
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;

   assign req_stall  = valid_ff && !item_take;
   assign load       = req_valid && !req_stall;
   assign valid_in   = load || (valid_ff && !item_take);
   assign item_in    = load ? item_type'{reply_byte: req_reply_byte, last_byte: req_last_byte}
                            : item_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ===== rtl/core/pmrp_parse.sv =====
// ----------------------------------------------------------------------------
// pmrp_parse
// Parse state and per-word update: prefix skip, host and port numbers.
// ----------------------------------------------------------------------------
module pmrp_parse
   import pmrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output result_type res
);

   phase_type              phase_ff, phase_in;
   logic [COUNT_W-1:0]     prefix_ff, prefix_in;
   logic [COUNT_W-1:0]     digits_ff, digits_in;
   logic [HOST_W-1:0]      value_ff, value_in;
   logic [HOST_W-1:0]      host_ff [HOST_COUNT];
   logic [HOST_W-1:0]      host_in [HOST_COUNT];
   logic [PORT_PART_W-1:0] port_hi_ff, port_hi_in;

   logic                  is_digit;
   logic                  is_comma;
   logic [3:0]            digit;
   logic [HOST_W-1:0]     host_acc;
   logic [PORT_ACC_W-1:0] port_acc;
   logic [HOST_IDX_W-1:0] host_idx;
   logic                  parsed_ok;

   always_comb begin
      is_digit = (item.reply_byte >= CHAR_ZERO) && (item.reply_byte <= CHAR_NINE);
      is_comma = (item.reply_byte == CHAR_COMMA);
      digit    = is_digit ? 4'(item.reply_byte - CHAR_ZERO) : 4'd0;
      host_acc = HOST_W'(value_ff * HOST_W'(10) + HOST_W'(digit));
      port_acc = PORT_ACC_W'(value_ff) * PORT_ACC_W'(10) + PORT_ACC_W'(digit);
      host_idx = HOST_IDX_W'(4'(phase_ff) - 4'(PH_HOST0));

      phase_in   = phase_ff;
      prefix_in  = prefix_ff;
      digits_in  = digits_ff;
      value_in   = value_ff;
      host_in    = host_ff;
      port_hi_in = port_hi_ff;

      unique case (phase_ff) inside
         PH_PREFIX: begin
            prefix_in = prefix_ff + 3'd1;
            if (prefix_in >= PREFIX_LEN) begin
               phase_in = PH_SEEK;
            end
         end
         PH_SEEK: begin
            if (is_digit) begin
               value_in  = HOST_W'(digit);
               digits_in = 3'd1;
               phase_in  = PH_HOST0;
            end
         end
         PH_HOST0, PH_HOST1, PH_HOST2, PH_HOST3: begin
            if (is_digit) begin
               if (digits_ff >= HOST_DIGITS) begin
                  phase_in = PH_ERROR;
               end else begin
                  value_in  = host_acc;
                  digits_in = digits_ff + 3'd1;
               end
            end else if (is_comma && digits_ff != '0) begin
               host_in[host_idx] = value_ff;
               phase_in          = phase_type'(4'(phase_ff) + 4'd1);
               value_in          = '0;
               digits_in         = '0;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_PORT_HI, PH_PORT_LO: begin
            if (is_digit) begin
               if (port_acc > PORT_MAX) begin
                  phase_in = PH_ERROR;
               end else begin
                  value_in = HOST_W'(port_acc);
                  if (digits_ff < DIGIT_SAT) begin
                     digits_in = digits_ff + 3'd1;
                  end
               end
            end else if (phase_ff == PH_PORT_HI) begin
               if (is_comma && digits_ff != '0) begin
                  port_hi_in = value_ff[PORT_PART_W-1:0];
                  phase_in   = PH_PORT_LO;
                  value_in   = '0;
                  digits_in  = '0;
               end else begin
                  phase_in = PH_ERROR;
               end
            end else if (digits_ff != '0) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      parsed_ok = (phase_in == PH_DONE) || (phase_in == PH_PORT_LO && digits_in != '0);

      res.valid_res   = parsed_ok;
      res.host_first  = parsed_ok ? host_in[0] : '0;
      res.host_second = parsed_ok ? host_in[1] : '0;
      res.host_third  = parsed_ok ? host_in[2] : '0;
      res.host_fourth = parsed_ok ? host_in[3] : '0;
      res.port_number = parsed_ok ? {port_hi_in, value_in[PORT_PART_W-1:0]} : '0;
   end

   // restart on reset and after the final word of every reply
   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         phase_ff   <= PH_PREFIX;
         prefix_ff  <= '0;
         digits_ff  <= '0;
         value_ff   <= '0;
         host_ff    <= '{default: '0};
         port_hi_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         prefix_ff  <= prefix_in;
         digits_ff  <= digits_in;
         value_ff   <= value_in;
         host_ff    <= host_in;
         port_hi_ff <= port_hi_in;
      end
   end

endmodule

// ===== rtl/core/pmrp_out_reg.sv =====
// ----------------------------------------------------------------------------
// pmrp_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module pmrp_out_reg
   import pmrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  result_type        res,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_valid_res,
   output logic [HOST_W-1:0] rsp_host_first,
   output logic [HOST_W-1:0] rsp_host_second,
   output logic [HOST_W-1:0] rsp_host_third,
   output logic [HOST_W-1:0] rsp_host_fourth,
   output logic [PORT_W-1:0] rsp_port_number
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);
   assign res_in   = load ? res : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_valid_res   = res_ff.valid_res;
   assign rsp_host_first  = res_ff.host_first;
   assign rsp_host_second = res_ff.host_second;
   assign rsp_host_third  = res_ff.host_third;
   assign rsp_host_fourth = res_ff.host_fourth;
   assign rsp_port_number = res_ff.port_number;

endmodule

// ===== rtl/core/pmrp_checker.sv =====
// ----------------------------------------------------------------------------
// pmrp_checker
// Port-level checks of the passive-mode reply parser, bound to the top level.
// ----------------------------------------------------------------------------
module pmrp_checker
   import pmrp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_valid_res,
   input logic [HOST_W-1:0] rsp_host_first,
   input logic [HOST_W-1:0] rsp_host_second,
   input logic [HOST_W-1:0] rsp_host_third,
   input logic [HOST_W-1:0] rsp_host_fourth,
   input logic [PORT_W-1:0] rsp_port_number
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res) &&
      $stable(rsp_port_number) && $stable(rsp_host_first))
      else $error("stalled result word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled without result back-pressure");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_port_number == '0 &&
      rsp_host_first == '0 && rsp_host_second == '0 &&
      rsp_host_third == '0 && rsp_host_fourth == '0)
      else $error("failed parse carries nonzero fields");

endmodule

bind passive_mode_reply_parser pmrp_checker u_pmrp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_valid_res   (rsp_valid_res),
   .rsp_host_first  (rsp_host_first),
   .rsp_host_second (rsp_host_second),
   .rsp_host_third  (rsp_host_third),
   .rsp_host_fourth (rsp_host_fourth),
   .rsp_port_number (rsp_port_number)
);
